### rtl/dt64_pkg.sv
// Shared types and constants for the decimal text to int64 converter.
package dt64_pkg;

    // ASCII codes the parser recognizes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Magnitude bounds: 2^63 and floor(2^63 / 10).
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_DIV10 = 64'd922337203685477580;

    // Parse phase of the current text.
    typedef enum logic [1:0] {
        PH_FIRST       = 2'd0,
        PH_AFTER_MINUS = 2'd1,
        PH_DIGITS      = 2'd2
    } t_phase;

    // One input beat: a text byte and its end marker.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic               ok;
        logic signed [63:0] number_value;
    } t_out_beat;

    // Parser state carried from byte to byte.
    typedef struct packed {
        t_phase      phase;
        logic        is_negative;
        logic [63:0] magnitude;
        logic        has_failed;
    } t_parse_state;

endpackage

### rtl/decimal_text_to_int64_top.sv
// Top level of the streaming decimal text to signed 64-bit integer converter.
//
//  Channel | Direction | Handshake                  | Beat
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data: char_code, last_char
//  out     | output    | o_out_valid / i_out_ready  | o_out_data: ok, number_value
//
// One text byte is taken per cycle unless a final byte is held back. A byte
// lands in the input register, the parse step runs on it there, and a final
// byte's result is loaded into the output register when that byte advances.
// Synchronous active-low reset returns the parser to the start of a text.
// A stalled result blocks only final bytes; other bytes keep flowing.
module decimal_text_to_int64_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dt64_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dt64_pkg::t_out_beat o_out_data
);

    logic                   r_in_valid;
    dt64_pkg::t_in_beat     r_in_data;
    dt64_pkg::t_parse_state r_state;
    dt64_pkg::t_parse_state n_state;
    logic                   r_out_valid;
    dt64_pkg::t_out_beat    r_out_data;
    dt64_pkg::t_out_beat    n_out_data;
    logic                   advance;

    // The held byte moves on unless it is final and the result slot is busy.
    assign advance    = r_in_valid && (!r_in_data.last_char || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Parse step.
    dt64_step u_step (
        .i_state  (r_state),
        .i_beat   (r_in_data),
        .o_state  (n_state),
        .o_result (n_out_data)
    );

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= dt64_pkg::PH_FIRST;
            r_state.is_negative <= 1'b0;
            r_state.magnitude   <= 64'd0;
            r_state.has_failed  <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_data.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_data.last_char) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/dt64_step.sv
// Per-byte parse step: next parser state and the result for a final byte.
module dt64_step (
    input  dt64_pkg::t_parse_state i_state,
    input  dt64_pkg::t_in_beat     i_beat,
    output dt64_pkg::t_parse_state o_state,
    output dt64_pkg::t_out_beat    o_result
);

    logic                   is_digit;
    logic                   is_nonzero_digit;
    logic                   lone_zero;
    logic [63:0]            digit_val;
    logic [63:0]            mag_times10;
    logic [63:0]            mag_next;
    dt64_pkg::t_parse_state upd;

    // Byte classification.
    assign is_digit = (i_beat.char_code >= dt64_pkg::CH_ZERO)
                   && (i_beat.char_code <= dt64_pkg::CH_NINE);
    assign is_nonzero_digit = (i_beat.char_code >= dt64_pkg::CH_ONE)
                           && (i_beat.char_code <= dt64_pkg::CH_NINE);
    assign digit_val = {60'd0, i_beat.char_code[3:0]};

    // Multiply by ten as a shift-add, then add the new digit. The sum cannot
    // wrap whenever the magnitude is within the divide-by-ten bound.
    assign mag_times10 = {i_state.magnitude[60:0], 3'b000}
                       + {i_state.magnitude[62:0], 1'b0};
    assign mag_next    = mag_times10 + digit_val;

    // State update for this byte.
    always_comb begin
        upd       = i_state;
        lone_zero = 1'b0;
        if (!i_state.has_failed) begin
            case (i_state.phase)
                dt64_pkg::PH_FIRST: begin
                    if (i_beat.char_code == dt64_pkg::CH_ZERO && i_beat.last_char) begin
                        lone_zero = 1'b1;
                    end else if (i_beat.char_code == dt64_pkg::CH_MINUS) begin
                        upd.is_negative = 1'b1;
                        upd.phase       = dt64_pkg::PH_AFTER_MINUS;
                        upd.has_failed  = i_beat.last_char;
                    end else if (is_nonzero_digit) begin
                        upd.magnitude = digit_val;
                        upd.phase     = dt64_pkg::PH_DIGITS;
                    end else begin
                        upd.has_failed = 1'b1;
                    end
                end
                dt64_pkg::PH_AFTER_MINUS: begin
                    if (is_nonzero_digit) begin
                        upd.magnitude = digit_val;
                        upd.phase     = dt64_pkg::PH_DIGITS;
                    end else begin
                        upd.has_failed = 1'b1;
                    end
                end
                default: begin
                    // Inside the digits: accumulate with overflow checks.
                    if (!is_digit) begin
                        upd.has_failed = 1'b1;
                    end else if (i_state.magnitude > dt64_pkg::MAG_DIV10) begin
                        upd.has_failed = 1'b1;
                    end else if (mag_next > dt64_pkg::MAG_LIMIT) begin
                        upd.has_failed = 1'b1;
                    end else begin
                        upd.magnitude = mag_next;
                    end
                end
            endcase
        end
    end

    // Result and return to the start state on the final byte.
    always_comb begin
        o_result.ok           = 1'b0;
        o_result.number_value = 64'sd0;
        o_state               = upd;
        if (lone_zero) begin
            o_result.ok = 1'b1;
        end else if (!upd.has_failed && upd.phase != dt64_pkg::PH_FIRST
                     && upd.phase != dt64_pkg::PH_AFTER_MINUS) begin
            if (upd.is_negative) begin
                o_result.ok           = 1'b1;
                o_result.number_value = $signed(64'd0 - upd.magnitude);
            end else if (upd.magnitude < dt64_pkg::MAG_LIMIT) begin
                o_result.ok           = 1'b1;
                o_result.number_value = $signed(upd.magnitude);
            end
        end
        if (i_beat.last_char) begin
            o_state.phase       = dt64_pkg::PH_FIRST;
            o_state.is_negative = 1'b0;
            o_state.magnitude   = 64'd0;
            o_state.has_failed  = 1'b0;
        end
    end

endmodule

### dv/testbench.sv
// Testbench for the streaming decimal text to signed 64-bit integer converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 13;
    localparam int MAX_REPORTS  = 10;

    // One directed byte, with the result typed in where it is obvious.
    typedef struct {
        logic [7:0]         ch;
        bit                 last;
        bit                 typed;
        bit                 ok;
        logic signed [63:0] value;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    dt64_pkg::t_in_beat  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    dt64_pkg::t_out_beat o_out_data;

    decimal_text_to_int64_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Parser state as the checker sees it.
    dt64_pkg::t_phase ps_phase    = dt64_pkg::PH_FIRST;
    logic             ps_negative = 1'b0;
    logic [63:0]      ps_mag      = '0;
    logic             ps_failed   = 1'b0;

    dt64_pkg::t_out_beat pending_numbers[$];
    logic [7:0]          text_bytes[$];
    int                  bad_results = 0;
    bit                  hold_req = 1'b0;
    bit                  calm_win = 1'b0;

    // Directed texts: lone zero, negative zero, bare minus, leading zero,
    // extreme byte codes, neighbors of the digit range and a doubled minus.
    t_dir_row directed_rows[23] = '{
        '{dt64_pkg::CH_ZERO,  1'b1, 1'b1, 1'b1, 64'sd0},
        '{dt64_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, 64'sd0},
        '{dt64_pkg::CH_ZERO,  1'b1, 1'b1, 1'b0, 64'sd0},
        '{dt64_pkg::CH_MINUS, 1'b1, 1'b1, 1'b0, 64'sd0},
        '{dt64_pkg::CH_ZERO,  1'b0, 1'b0, 1'b0, 64'sd0},
        '{"5",                1'b1, 1'b1, 1'b0, 64'sd0},
        '{8'hFF,              1'b1, 1'b1, 1'b0, 64'sd0},
        '{8'h00,              1'b1, 1'b1, 1'b0, 64'sd0},
        '{dt64_pkg::CH_NINE,  1'b1, 1'b1, 1'b1, 64'sd9},
        '{dt64_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, 64'sd0},
        '{dt64_pkg::CH_ONE,   1'b1, 1'b1, 1'b1, -64'sd1},
        '{dt64_pkg::CH_ONE,   1'b0, 1'b0, 1'b0, 64'sd0},
        '{"/",                1'b1, 1'b1, 1'b0, 64'sd0},
        '{dt64_pkg::CH_ONE,   1'b0, 1'b0, 1'b0, 64'sd0},
        '{":",                1'b1, 1'b1, 1'b0, 64'sd0},
        '{dt64_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, 64'sd0},
        '{dt64_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, 64'sd0},
        '{dt64_pkg::CH_ONE,   1'b1, 1'b1, 1'b0, 64'sd0},
        '{"4",                1'b0, 1'b0, 1'b0, 64'sd0},
        '{"2",                1'b1, 1'b0, 1'b0, 64'sd0},
        '{dt64_pkg::CH_MINUS, 1'b0, 1'b0, 1'b0, 64'sd0},
        '{"8",                1'b0, 1'b0, 1'b0, 64'sd0},
        '{dt64_pkg::CH_ZERO,  1'b1, 1'b0, 1'b0, 64'sd0}
    };

    // Advance the parser by one byte; a final byte yields the parsed number.
    task automatic parse_byte(input dt64_pkg::t_in_beat b, output bit has_result,
                              output dt64_pkg::t_out_beat res);
        logic [7:0]  c;
        logic [63:0] dig;
        logic [63:0] nxt;
        bit          lone_zero;
        c = b.char_code;
        dig = 64'(c) - 64'(dt64_pkg::CH_ZERO);
        lone_zero = 1'b0;
        has_result = 1'b0;
        res = '0;
        if (!ps_failed) begin
            case (ps_phase)
                dt64_pkg::PH_FIRST: begin
                    if (c == dt64_pkg::CH_ZERO && b.last_char) begin
                        lone_zero = 1'b1;
                    end else if (c == dt64_pkg::CH_MINUS) begin
                        ps_negative = 1'b1;
                        ps_phase = dt64_pkg::PH_AFTER_MINUS;
                        if (b.last_char) ps_failed = 1'b1;
                    end else if (c >= dt64_pkg::CH_ONE && c <= dt64_pkg::CH_NINE) begin
                        ps_mag = dig;
                        ps_phase = dt64_pkg::PH_DIGITS;
                    end else begin
                        ps_failed = 1'b1;
                    end
                end
                dt64_pkg::PH_AFTER_MINUS: begin
                    if (c >= dt64_pkg::CH_ONE && c <= dt64_pkg::CH_NINE) begin
                        ps_mag = dig;
                        ps_phase = dt64_pkg::PH_DIGITS;
                    end else begin
                        ps_failed = 1'b1;
                    end
                end
                default: begin
                    if (c >= dt64_pkg::CH_ZERO && c <= dt64_pkg::CH_NINE) begin
                        // Reject as soon as the magnitude would pass 2^63.
                        if (ps_mag > dt64_pkg::MAG_DIV10) begin
                            ps_failed = 1'b1;
                        end else begin
                            nxt = ps_mag * 64'd10 + dig;
                            if (nxt > dt64_pkg::MAG_LIMIT) ps_failed = 1'b1;
                            else ps_mag = nxt;
                        end
                    end else begin
                        ps_failed = 1'b1;
                    end
                end
            endcase
        end
        if (b.last_char) begin
            has_result = 1'b1;
            if (lone_zero) begin
                res.ok = 1'b1;
            end else if (!ps_failed && ps_phase == dt64_pkg::PH_DIGITS) begin
                if (ps_negative) begin
                    res.ok = 1'b1;
                    res.number_value = 64'd0 - ps_mag;
                end else if (ps_mag < dt64_pkg::MAG_LIMIT) begin
                    res.ok = 1'b1;
                    res.number_value = ps_mag;
                end
            end
            ps_phase = dt64_pkg::PH_FIRST;
            ps_negative = 1'b0;
            ps_mag = '0;
            ps_failed = 1'b0;
        end
    endtask

    // Offer one beat, with random idle cycles unless calm, until accepted.
    task automatic send_beat(input dt64_pkg::t_in_beat b, input bit calm);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Append n random digits, the first one nonzero.
    task automatic push_digits(input int n);
        text_bytes.push_back(dt64_pkg::CH_ONE + 8'($urandom_range(8)));
        for (int i = 1; i < n; i++) begin
            text_bytes.push_back(dt64_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // Build one random text: mostly well-formed, some broken, some noise.
    task automatic make_text();
        int          kind;
        int          sel;
        bit          neg;
        logic [63:0] near;
        string       s;
        text_bytes.delete();
        kind = $urandom_range(99);
        neg = 1'($urandom_range(1));
        if (kind < 62) begin
            if (neg) text_bytes.push_back(dt64_pkg::CH_MINUS);
            sel = $urandom_range(99);
            if (sel < 10) begin
                text_bytes.push_back(dt64_pkg::CH_ZERO);
            end else if (sel < 45) begin
                push_digits($urandom_range(1, 4));
            end else if (sel < 75) begin
                push_digits($urandom_range(5, 19));
            end else if (sel < 90) begin
                // Values around 2^63 - 1 and 2^63.
                near = 64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(4)) - 64'd2;
                s = $sformatf("%0d", near);
                for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
            end else begin
                push_digits($urandom_range(20, 24));
            end
        end else if (kind < 85) begin
            if (neg) text_bytes.push_back(dt64_pkg::CH_MINUS);
            push_digits($urandom_range(1, 8));
            if ($urandom_range(1)) begin
                sel = $urandom_range(text_bytes.size() - 1);
                text_bytes[sel] = 8'($urandom_range(255));
            end else begin
                text_bytes.insert(neg ? 1 : 0, dt64_pkg::CH_ZERO);
            end
        end else begin
            repeat ($urandom_range(1, 5)) text_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // Result side: random stalls, one long hold-off on request, a calm window.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm_win) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each result beat with the oldest expected number.
    always @(posedge i_clk) begin
        dt64_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_numbers.size() == 0) begin
                if (bad_results < MAX_REPORTS)
                    $display("unexpected result: ok=%0b value=%0d",
                             o_out_data.ok, o_out_data.number_value);
                bad_results++;
            end else begin
                want = pending_numbers.pop_front();
                if (o_out_data.ok !== want.ok ||
                    o_out_data.number_value !== want.number_value) begin
                    if (bad_results < MAX_REPORTS)
                        $display("mismatch: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                                 want.ok, want.number_value,
                                 o_out_data.ok, o_out_data.number_value);
                    bad_results++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random texts.
    initial begin
        dt64_pkg::t_in_beat  b;
        dt64_pkg::t_out_beat res;
        bit                  got;
        int                  sent;
        int                  text_idx;
        sent = 0;
        text_idx = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            b.char_code = directed_rows[i].ch;
            b.last_char = directed_rows[i].last;
            send_beat(b, 1'b0);
            parse_byte(b, got, res);
            if (got) begin
                if (directed_rows[i].typed) begin
                    res.ok = directed_rows[i].ok;
                    res.number_value = directed_rows[i].value;
                end
                pending_numbers.push_back(res);
            end
        end

        while (sent < RANDOM_BYTES) begin
            // Long result stall while bytes keep coming.
            if (text_idx == 30) hold_req = 1'b1;
            // Let everything drain before going on.
            if (text_idx == 60) begin
                i_in_valid <= 1'b0;
                while (pending_numbers.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            // Both sides run without idling for a stretch of texts.
            calm_win = (text_idx >= 70 && text_idx < 100);
            make_text();
            foreach (text_bytes[i]) begin
                b.char_code = text_bytes[i];
                b.last_char = (i == text_bytes.size() - 1);
                send_beat(b, calm_win);
                parse_byte(b, got, res);
                if (got) pending_numbers.push_back(res);
                sent++;
            end
            text_idx++;
        end
        calm_win = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (bad_results == 0 && pending_numbers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/dt64_pkg.sv
rtl/dt64_step.sv
rtl/decimal_text_to_int64_top.sv
dv/testbench.sv
